>>> rtl/core/fmrpt_pkg.sv
// Shared types and constants for the FM chip register port and timers.
package fmrpt_pkg;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [7:0] SEL_TA_HIGH    = 8'h24;
    localparam logic [7:0] SEL_TA_LOW     = 8'h25;
    localparam logic [7:0] SEL_TB         = 8'h26;
    localparam logic [7:0] SEL_CONTROL    = 8'h27;
    localparam logic [7:0] SEL_DAC_SAMPLE = 8'h2a;
    localparam logic [7:0] SEL_DAC_ENABLE = 8'h2b;

    // control register bit positions
    localparam int CTRL_LOAD_A  = 0;
    localparam int CTRL_LOAD_B  = 1;
    localparam int CTRL_EN_A    = 2;
    localparam int CTRL_EN_B    = 3;
    localparam int CTRL_RESET_A = 4;
    localparam int CTRL_RESET_B = 5;
    localparam logic [7:0] CTRL_STORE_MASK = 8'hcf;

    localparam int FLAG_A = 0;
    localparam int FLAG_B = 1;

    localparam int COUNT_W    = 32;
    localparam int A_PERIOD_W = 15;
    localparam int B_PERIOD_W = 17;
    localparam logic [10:0] TIMER_A_BASE = 11'd1024;
    localparam logic [8:0]  TIMER_B_BASE = 9'd256;
    localparam logic [A_PERIOD_W-1:0] TIMER_A_SCALE = 15'd18;
    localparam logic [B_PERIOD_W-1:0] TIMER_B_SCALE = 17'd288;

    typedef struct packed {
        logic [7:0] read_data;
        logic       forward_to_core;
        logic       dac_sample_write;
        logic       dac_enable_write;
    } result_t;

endpackage

>>> rtl/core/fm_chip_register_port_timers.sv
// Register port, DAC decode and the two interval timers of an FM sound chip front end.
//
// Every transaction (bus write, status read or elapsed-time tick) is handled in the
// cycle it is accepted: state updates and the result is registered at that same edge,
// so one transaction is taken per cycle while in_stall is low. The 32-bit timer add
// followed by the period compare sets the cycle's logic depth. A two-entry output
// buffer (result register plus skid register) keeps the input open while a result
// waits; in_stall rises only when both entries are full.
module fm_chip_register_port_timers (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [1:0] port_addr,
    input  logic [7:0] write_data,
    input  logic [15:0] elapsed_us,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       forward_to_core,
    output logic       dac_sample_write,
    output logic       dac_enable_write
);
    import fmrpt_pkg::*;

    logic [7:0]         select_port0_reg, select_port0_next;
    logic [7:0]         select_port1_reg, select_port1_next;
    logic [7:0]         timer_a_high_reg, timer_a_high_next;
    logic [1:0]         timer_a_low_reg, timer_a_low_next;
    logic [7:0]         timer_b_value_reg, timer_b_value_next;
    logic [7:0]         timer_control_reg, timer_control_next;
    logic [1:0]         overflow_flags_reg, overflow_flags_next;
    logic [COUNT_W-1:0] count_a_reg, count_a_next;
    logic [COUNT_W-1:0] count_b_reg, count_b_next;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg, result;

    logic accept, out_fire, out_free;

    logic                  port_sel;
    logic [7:0]            sel;
    logic [10:0]           a_span;
    logic [8:0]            b_span;
    logic [A_PERIOD_W-1:0] a_period;
    logic [B_PERIOD_W-1:0] b_period;
    logic [COUNT_W-1:0]    sum_a, sum_b;
    logic [COUNT_W:0]      diff_a, diff_b;

    assign accept   = in_valid && !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || out_fire;

    assign port_sel = port_addr[1];
    assign sel      = port_sel ? select_port1_reg : select_port0_reg;

    // periods: A = 18*(1024-TA10), B = 288*(256-TB)
    assign a_span   = TIMER_A_BASE - {1'b0, timer_a_high_reg, timer_a_low_reg};
    assign b_span   = TIMER_B_BASE - {1'b0, timer_b_value_reg};
    assign a_period = {4'b0, a_span} * TIMER_A_SCALE;
    assign b_period = {8'b0, b_span} * TIMER_B_SCALE;

    assign sum_a  = count_a_reg + {16'b0, elapsed_us};
    assign sum_b  = count_b_reg + {16'b0, elapsed_us};
    assign diff_a = {1'b0, sum_a} - {{(COUNT_W + 1 - A_PERIOD_W){1'b0}}, a_period};
    assign diff_b = {1'b0, sum_b} - {{(COUNT_W + 1 - B_PERIOD_W){1'b0}}, b_period};

    always_comb
    begin
        select_port0_next   = select_port0_reg;
        select_port1_next   = select_port1_reg;
        timer_a_high_next   = timer_a_high_reg;
        timer_a_low_next    = timer_a_low_reg;
        timer_b_value_next  = timer_b_value_reg;
        timer_control_next  = timer_control_reg;
        overflow_flags_next = overflow_flags_reg;
        count_a_next        = count_a_reg;
        count_b_next        = count_b_reg;
        result              = '0;

        case (mode_t'(mode))
            MODE_WRITE:
            begin
                if (!port_addr[0])
                begin
                    if (port_sel)
                        select_port1_next = write_data;
                    else
                        select_port0_next = write_data;
                    result.forward_to_core = 1'b1;
                end
                else if (sel == SEL_DAC_SAMPLE)
                begin
                    result.dac_sample_write = 1'b1;
                end
                else if (sel == SEL_DAC_ENABLE)
                begin
                    result.dac_enable_write = 1'b1;
                end
                else
                begin
                    result.forward_to_core = 1'b1;
                    if (sel == SEL_CONTROL)
                    begin
                        // restart on a rising load bit against the stored port-0 control
                        if (write_data[CTRL_LOAD_A] && !timer_control_reg[CTRL_LOAD_A])
                            count_a_next = '0;
                        if (write_data[CTRL_LOAD_B] && !timer_control_reg[CTRL_LOAD_B])
                            count_b_next = '0;
                        if (write_data[CTRL_RESET_A])
                            overflow_flags_next[FLAG_A] = 1'b0;
                        if (write_data[CTRL_RESET_B])
                            overflow_flags_next[FLAG_B] = 1'b0;
                        if (!port_sel)
                            timer_control_next = write_data & CTRL_STORE_MASK;
                    end
                    else if (!port_sel)
                    begin
                        if (sel == SEL_TA_HIGH)
                            timer_a_high_next = write_data;
                        else if (sel == SEL_TA_LOW)
                            timer_a_low_next = write_data[1:0];
                        else if (sel == SEL_TB)
                            timer_b_value_next = write_data;
                    end
                end
            end
            MODE_READ:
            begin
                result.read_data = {6'b0, overflow_flags_reg};
            end
            MODE_TICK:
            begin
                // a zero tick must not trigger a pending wrap after a period change
                if (elapsed_us != 16'd0)
                begin
                    if (timer_control_reg[CTRL_LOAD_A])
                    begin
                        if (diff_a[COUNT_W])
                        begin
                            count_a_next = sum_a;
                        end
                        else
                        begin
                            count_a_next = diff_a[COUNT_W-1:0];
                            if (timer_control_reg[CTRL_EN_A])
                                overflow_flags_next[FLAG_A] = 1'b1;
                        end
                    end
                    if (timer_control_reg[CTRL_LOAD_B])
                    begin
                        if (diff_b[COUNT_W])
                        begin
                            count_b_next = sum_b;
                        end
                        else
                        begin
                            count_b_next = diff_b[COUNT_W-1:0];
                            if (timer_control_reg[CTRL_EN_B])
                                overflow_flags_next[FLAG_B] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_port0_reg   <= '0;
            select_port1_reg   <= '0;
            timer_a_high_reg   <= '0;
            timer_a_low_reg    <= '0;
            timer_b_value_reg  <= '0;
            timer_control_reg  <= '0;
            overflow_flags_reg <= '0;
            count_a_reg        <= '0;
            count_b_reg        <= '0;
        end
        else if (accept)
        begin
            select_port0_reg   <= select_port0_next;
            select_port1_reg   <= select_port1_next;
            timer_a_high_reg   <= timer_a_high_next;
            timer_a_low_reg    <= timer_a_low_next;
            timer_b_value_reg  <= timer_b_value_next;
            timer_control_reg  <= timer_control_next;
            overflow_flags_reg <= overflow_flags_next;
            count_a_reg        <= count_a_next;
            count_b_reg        <= count_b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result;
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = out_reg.read_data;
    assign forward_to_core  = out_reg.forward_to_core;
    assign dac_sample_write = out_reg.dac_sample_write;
    assign dac_enable_write = out_reg.dac_enable_write;

    // skid entry only fills behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without a result in the output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.read_data[7:2] == 6'd0))
        else $error("status byte has bits set above the overflow flags");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($countones({out_reg.forward_to_core, out_reg.dac_sample_write,
                                       out_reg.dac_enable_write}) <= 1))
        else $error("write routed to more than one destination");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_t'(mode) == MODE_TICK && elapsed_us == 16'd0)
            |=> ($stable(count_a_reg) && $stable(count_b_reg)))
        else $error("zero tick changed a timer count");

endmodule

>>> bench/testbench.sv
// Self-checking bench for the FM chip register port, DAC decode and interval timers.
module testbench;
    import fmrpt_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [1:0] PORT0_SEL  = 2'd0;
    localparam logic [1:0] PORT0_DATA = 2'd1;
    localparam logic [1:0] PORT1_SEL  = 2'd2;
    localparam logic [1:0] PORT1_DATA = 2'd3;

    localparam result_t EXP_IDLE       = {8'h00, 1'b0, 1'b0, 1'b0};
    localparam result_t EXP_FORWARD    = {8'h00, 1'b1, 1'b0, 1'b0};
    localparam result_t EXP_DAC_SAMPLE = {8'h00, 1'b0, 1'b1, 1'b0};
    localparam result_t EXP_DAC_ENABLE = {8'h00, 1'b0, 1'b0, 1'b1};
    localparam result_t EXP_BOTH_FLAGS = {8'h03, 1'b0, 1'b0, 1'b0};

    typedef struct packed {
        mode_t       op;
        logic [1:0]  addr;
        logic [7:0]  data;
        logic [15:0] dt;
        logic        typed;
        result_t     want;
    } stim_row_t;

    localparam int N_DIRECTED = 27;

    // rows with typed=0 take their expectation from the timer model
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{MODE_READ,  PORT0_SEL,  8'h00,          16'h0000, 1'b1, EXP_IDLE},
        '{MODE_NONE,  PORT1_DATA, 8'hff,          16'hffff, 1'b1, EXP_IDLE},
        '{MODE_WRITE, PORT0_SEL,  SEL_DAC_SAMPLE, 16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_WRITE, PORT0_DATA, 8'hff,          16'h0000, 1'b1, EXP_DAC_SAMPLE},
        '{MODE_WRITE, PORT1_SEL,  SEL_DAC_ENABLE, 16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_WRITE, PORT1_DATA, 8'h00,          16'h0000, 1'b1, EXP_DAC_ENABLE},
        '{MODE_WRITE, PORT0_SEL,  SEL_TA_HIGH,    16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_WRITE, PORT0_DATA, 8'hff,          16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_WRITE, PORT0_SEL,  SEL_TA_LOW,     16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_WRITE, PORT0_DATA, 8'hff,          16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_WRITE, PORT0_SEL,  SEL_TB,         16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_WRITE, PORT0_DATA, 8'hff,          16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_WRITE, PORT0_SEL,  SEL_CONTROL,    16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_WRITE, PORT0_DATA, 8'hff,          16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_TICK,  PORT0_SEL,  8'h00,          16'h0000, 1'b0, EXP_IDLE},
        '{MODE_TICK,  PORT0_SEL,  8'h00,          16'hffff, 1'b0, EXP_IDLE},
        '{MODE_READ,  PORT0_SEL,  8'h00,          16'h0000, 1'b1, EXP_BOTH_FLAGS},
        // port-1 control: clears flags, stored control untouched
        '{MODE_WRITE, PORT1_SEL,  SEL_CONTROL,    16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_WRITE, PORT1_DATA, 8'h30,          16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_READ,  PORT0_SEL,  8'h00,          16'h0000, 1'b1, EXP_IDLE},
        '{MODE_WRITE, PORT1_SEL,  SEL_TA_HIGH,    16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_WRITE, PORT1_DATA, 8'h00,          16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_TICK,  PORT0_SEL,  8'h00,          16'h0001, 1'b0, EXP_IDLE},
        '{MODE_READ,  PORT0_SEL,  8'h00,          16'h0000, 1'b0, EXP_IDLE},
        // stop both timers and clear flags; a long tick must then do nothing
        '{MODE_WRITE, PORT0_DATA, 8'h30,          16'h0000, 1'b1, EXP_FORWARD},
        '{MODE_TICK,  PORT0_SEL,  8'h00,          16'hffff, 1'b0, EXP_IDLE},
        '{MODE_READ,  PORT0_SEL,  8'h00,          16'h0000, 1'b1, EXP_IDLE}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [1:0]  port_addr;
    logic [7:0]  write_data;
    logic [15:0] elapsed_us;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic        forward_to_core;
    logic        dac_sample_write;
    logic        dac_enable_write;

    fm_chip_register_port_timers dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .port_addr        (port_addr),
        .write_data       (write_data),
        .elapsed_us       (elapsed_us),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .read_data        (read_data),
        .forward_to_core  (forward_to_core),
        .dac_sample_write (dac_sample_write),
        .dac_enable_write (dac_enable_write)
    );

    // timer model state
    logic [7:0]  sel_latch [0:1];
    logic [7:0]  ta_hi;
    logic [1:0]  ta_lo;
    logic [7:0]  tb_val;
    logic [7:0]  ctrl_stored;
    logic [1:0]  flags;
    logic [31:0] acc_a;
    logic [31:0] acc_b;

    result_t predicted_replies [$];
    logic    row_typed;
    result_t row_want;
    result_t model_reply;
    result_t got;
    result_t want;
    int      error_count;
    int      cycle_count;
    int      burst_left;
    int      stall_phase_left;
    int      stall_style;

    function automatic result_t apply_bus_transaction(input mode_t op, input logic [1:0] addr,
                                                      input logic [7:0] data,
                                                      input logic [15:0] dt);
        result_t     r;
        logic        port;
        logic [7:0]  sel;
        logic [31:0] a_period;
        logic [31:0] b_period;
        r = '0;
        port = addr[1];
        case (op)
            MODE_WRITE:
            begin
                if (!addr[0])
                begin
                    sel_latch[port] = data;
                    r.forward_to_core = 1'b1;
                end
                else
                begin
                    sel = sel_latch[port];
                    if (sel == SEL_DAC_SAMPLE)
                        r.dac_sample_write = 1'b1;
                    else if (sel == SEL_DAC_ENABLE)
                        r.dac_enable_write = 1'b1;
                    else
                    begin
                        r.forward_to_core = 1'b1;
                        if (sel == SEL_CONTROL)
                        begin
                            // restart only on a rising load bit vs. stored port-0 control
                            if (data[CTRL_LOAD_A] && !ctrl_stored[CTRL_LOAD_A])
                                acc_a = '0;
                            if (data[CTRL_LOAD_B] && !ctrl_stored[CTRL_LOAD_B])
                                acc_b = '0;
                            if (data[CTRL_RESET_A])
                                flags[FLAG_A] = 1'b0;
                            if (data[CTRL_RESET_B])
                                flags[FLAG_B] = 1'b0;
                            if (!port)
                                ctrl_stored = data & CTRL_STORE_MASK;
                        end
                        else if (!port)
                        begin
                            if (sel == SEL_TA_HIGH)
                                ta_hi = data;
                            else if (sel == SEL_TA_LOW)
                                ta_lo = data[1:0];
                            else if (sel == SEL_TB)
                                tb_val = data;
                        end
                    end
                end
            end
            MODE_READ:
                r.read_data = {6'd0, flags};
            MODE_TICK:
            begin
                a_period = 32'(TIMER_A_SCALE) * (32'(TIMER_A_BASE) - 32'({ta_hi, ta_lo}));
                b_period = 32'(TIMER_B_SCALE) * (32'(TIMER_B_BASE) - 32'(tb_val));
                if (dt != '0)
                begin
                    if (ctrl_stored[CTRL_LOAD_A])
                    begin
                        acc_a = acc_a + 32'(dt);
                        if (acc_a >= a_period)
                        begin
                            if (ctrl_stored[CTRL_EN_A])
                                flags[FLAG_A] = 1'b1;
                            acc_a = acc_a - a_period;
                        end
                    end
                    if (ctrl_stored[CTRL_LOAD_B])
                    begin
                        acc_b = acc_b + 32'(dt);
                        if (acc_b >= b_period)
                        begin
                            if (ctrl_stored[CTRL_EN_B])
                                flags[FLAG_B] = 1'b1;
                            acc_b = acc_b - b_period;
                        end
                    end
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic compare_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0h, got %0h", field, exp_val, act_val);
            error_count++;
        end
    endtask

    // one transaction on the input channel; bursts with random gaps in between
    task automatic issue(input mode_t op, input logic [1:0] addr, input logic [7:0] data,
                         input logic [15:0] dt, input logic typed, input result_t exp_reply);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        mode       = op;
        port_addr  = addr;
        write_data = data;
        elapsed_us = dt;
        row_typed  = typed;
        row_want   = exp_reply;
        in_valid   = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic run_random_traffic();
        int          counted;
        int          pick;
        logic        port;
        logic [7:0]  sel;
        logic [7:0]  data;
        logic [15:0] dt;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // select then data: the sequence that actually reaches the timers
                port = ($urandom_range(0, 4) == 0);
                case ($urandom_range(0, 7))
                    0: sel = SEL_TA_HIGH;
                    1: sel = SEL_TA_LOW;
                    2: sel = SEL_TB;
                    3, 4: sel = SEL_CONTROL;
                    5: sel = SEL_DAC_SAMPLE;
                    6: sel = SEL_DAC_ENABLE;
                    default: sel = 8'($urandom);
                endcase
                data = 8'($urandom);
                // mostly short periods so overflows show up often
                if ((sel == SEL_TA_HIGH || sel == SEL_TB) && $urandom_range(0, 3) != 0)
                    data = 8'($urandom_range(224, 255));
                issue(MODE_WRITE, {port, 1'b0}, sel, 16'($urandom), 1'b0, EXP_IDLE);
                issue(MODE_WRITE, {port, 1'b1}, data, 16'($urandom), 1'b0, EXP_IDLE);
                counted += 2;
            end
            else if (pick < 60)
            begin
                issue(MODE_READ, 2'($urandom), 8'($urandom), 16'($urandom), 1'b0, EXP_IDLE);
                counted++;
            end
            else if (pick < 90)
            begin
                case ($urandom_range(0, 19))
                    0: dt = '0;
                    1, 2: dt = 16'($urandom);
                    3, 4, 5: dt = 16'($urandom_range(0, 5000));
                    default: dt = 16'($urandom_range(1, 400));
                endcase
                issue(MODE_TICK, 2'($urandom), 8'($urandom), dt, 1'b0, EXP_IDLE);
                counted++;
            end
            else if (pick < 95)
            begin
                issue(MODE_WRITE, 2'($urandom), 8'($urandom), 16'($urandom), 1'b0, EXP_IDLE);
                counted++;
            end
            else
            begin
                issue(MODE_NONE, 2'($urandom), 8'($urandom), 16'($urandom), 1'b0, EXP_IDLE);
            end
        end
    endtask

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // receiver: stretches of no stall, light stall and heavy stall
    always @(negedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_phase_left = $urandom_range(20, 120);
            stall_style = $urandom_range(0, 2);
        end
        stall_phase_left--;
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            model_reply = apply_bus_transaction(mode_t'(mode), port_addr, write_data,
                                                elapsed_us);
            predicted_replies.push_back(row_typed ? row_want : model_reply);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = {read_data, forward_to_core, dac_sample_write, dac_enable_write};
            if (predicted_replies.size() == 0)
            begin
                $error("result with no transaction pending: %0h", got);
                error_count++;
            end
            else
            begin
                want = predicted_replies.pop_front();
                compare_field("read_data", want.read_data, got.read_data);
                compare_field("forward_to_core", want.forward_to_core, got.forward_to_core);
                compare_field("dac_sample_write", want.dac_sample_write,
                              got.dac_sample_write);
                compare_field("dac_enable_write", want.dac_enable_write,
                              got.dac_enable_write);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fm_chip_register_port_timers: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        mode             = MODE_WRITE;
        port_addr        = '0;
        write_data       = '0;
        elapsed_us       = '0;
        out_stall        = 1'b0;
        row_typed        = 1'b0;
        row_want         = EXP_IDLE;
        error_count      = 0;
        cycle_count      = 0;
        burst_left       = 0;
        stall_phase_left = 0;
        stall_style      = 0;
        sel_latch[0]     = '0;
        sel_latch[1]     = '0;
        ta_hi            = '0;
        ta_lo            = '0;
        tb_val           = '0;
        ctrl_stored      = '0;
        flags            = '0;
        acc_a            = '0;
        acc_b            = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            issue(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                  directed_rows[i].dt, directed_rows[i].typed, directed_rows[i].want);
        end
        run_random_traffic();
        in_valid = 1'b0;

        while (predicted_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("fm_chip_register_port_timers: match");
        else
            $display("fm_chip_register_port_timers: mismatch");
        $finish;
    end

endmodule
